// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define RPG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked at every edge, reset included
`define RPG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPG_ASSERT(lbl, clk, rstn, prop, msg)
`define RPG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/rpg_pkg.sv =====
// ---------------------------------------------------------------------------
// rpg_pkg
// Widths, register codes and the quarter-wave sine builder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package rpg_pkg;
  localparam int STB = 10;                      // sine table bits
  localparam int RFB = 16;                      // ramp ratio fraction bits
  localparam int FB  = (RFB > 16) ? RFB : 16;   // quotient bits from divider
  localparam int TW  = 48;                      // time width
  localparam int PW  = 32;                      // period width
  localparam int DW  = TW + FB;                 // divider steps
  localparam int N   = 1 << STB;
  localparam logic [63:0] PIH = 64'd1686629713;
  localparam logic [63:0] ONE = 64'd1 << 30;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_LEVEL_A = 3'd1,
    REG_LEVEL_B = 3'd2,
    REG_PERIOD  = 3'd3,
    REG_PHASE   = 3'd4,
    REG_DUTY    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_CONST  = 2'd0,
    MODE_SINE   = 2'd1,
    MODE_SQUARE = 2'd2,
    MODE_RAMP   = 2'd3
  } mode_t;

  typedef struct packed {
    logic          valid;
    logic [FB-1:0] frac;   // floor(pos * 2^FB / P)
    logic          t_ge;   // time at or beyond one period
  } div_out_t;

  typedef logic [16:0] rom_t [0:N];

  function automatic logic [16:0] quarter_sine(input int unsigned j);
    logic [63:0] x, x2, t, s, q;
    x  = (64'(j) * PIH) >> STB;
    x2 = (x * x) >> 30;
    t  = ONE;
    t  = ONE - (((x2 * t) >> 30) / 64'd110);
    t  = ONE - (((x2 * t) >> 30) / 64'd72);
    t  = ONE - (((x2 * t) >> 30) / 64'd42);
    t  = ONE - (((x2 * t) >> 30) / 64'd20);
    t  = ONE - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    q  = (s + 64'd8192) >> 14;
    if (q > 64'd65536) q = 64'd65536;
    return q[16:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned k = 0; k <= N; k++) r[k] = quarter_sine(k);
    return r;
  endfunction
endpackage

// ===== rtl/core/rpg_divider.sv =====
// ---------------------------------------------------------------------------
// rpg_divider
// Bit-per-stage restoring divider: time mod period, then fraction of period.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rpg_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [rpg_pkg::TW-1:0] in_time,
  input  logic [rpg_pkg::PW-1:0] period,
  output rpg_pkg::div_out_t    dout
);
  import rpg_pkg::*;

  logic          v_r   [0:DW];
  logic [PW-1:0] rem_r [0:DW];
  logic [TW-1:0] tsh_r [0:DW];
  logic [FB-1:0] q_r   [0:DW];
  logic          ge_r  [0:DW];

  // entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
    if (adv) begin
      rem_r[0] <= '0;
      tsh_r[0] <= in_time;
      q_r[0]   <= '0;
      ge_r[0]  <= (in_time >= {{(TW-PW){1'b0}}, period});
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic [PW:0] c;
    logic [PW:0] d;
    logic        qb;
    always_comb begin
      c  = {rem_r[k], tsh_r[k][TW-1]};
      d  = c - {1'b0, period};
      qb = (c >= {1'b0, period});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
      if (adv) begin
        rem_r[k+1] <= qb ? d[PW-1:0] : c[PW-1:0];
        tsh_r[k+1] <= {tsh_r[k][TW-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][FB-2:0], qb};
        ge_r[k+1]  <= ge_r[k];
      end
    end
  end

  assign dout.valid = v_r[DW];
  assign dout.frac  = q_r[DW];
  assign dout.t_ge  = ge_r[DW];

  `RPG_ASSERT(a_rem_lt_period, clk, rst_n, v_r[DW] |-> (rem_r[DW] < period), "remainder not below period")
endmodule

// ===== rtl/core/rpg_shaper.sv =====
// ---------------------------------------------------------------------------
// rpg_shaper
// Angle, sine table, products, mode select and saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rpg_shaper (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  rpg_pkg::div_out_t    din,
  input  logic [1:0]           mode,
  input  logic [31:0]          level_a,
  input  logic signed [32:0]   level_b,
  input  logic [15:0]          phase_turn,
  input  logic [16:0]          duty_frac,
  output logic                 out_valid,
  output logic [31:0]          out_rate
);
  import rpg_pkg::*;

  localparam rom_t ROM = build_rom();
  localparam int RPW = 34 + RFB + 2;

  // stage 1
  logic              v1_r, sq1_r, neg1_r;
  logic [STB:0]      addr1_r;
  logic [RFB:0]      r1_r;
  logic [15:0]       ang;
  logic [STB+1:0]    idx;
  logic [STB:0]      addr_nxt;
  // stage 2
  logic              v2_r, sq2_r, neg2_r;
  logic [16:0]       mag2_r;
  logic signed [RPW-1:0] rp2_r;
  // stage 3
  logic              v3_r, sq3_r;
  logic signed [50:0] sp3_r;
  logic signed [RPW-1:0] rp3_r;
  // stage 4
  logic              v4_r;
  logic [31:0]       rate_r;

  logic signed [33:0] diff;
  logic signed [17:0] sgn;
  logic signed [36:0] sum, a37;
  logic [31:0]        rate_nxt;

  always_comb begin
    ang      = din.frac[FB-1 -: 16] + phase_turn;
    idx      = ang[15 -: STB+2];
    addr_nxt = idx[STB] ? ((STB+1)'(N) - {1'b0, idx[STB-1:0]}) : {1'b0, idx[STB-1:0]};
    diff     = {level_b[32], level_b} - $signed({2'b00, level_a});
    sgn      = neg2_r ? -$signed({1'b0, mag2_r}) : $signed({1'b0, mag2_r});
    a37      = $signed({5'b0, level_a});
    case (mode_t'(mode))
      MODE_CONST:  sum = a37;
      MODE_SINE:   sum = a37 + 37'($signed(sp3_r[50:16]));
      MODE_SQUARE: sum = sq3_r ? a37 : '0;
      MODE_RAMP:   sum = a37 + 37'($signed(rp3_r[RPW-1:RFB]));
      default:     sum = a37;
    endcase
    if (sum[36])               rate_nxt = '0;
    else if (sum[35:32] != '0) rate_nxt = '1;
    else                       rate_nxt = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= din.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    if (adv) begin
      sq1_r   <= ({1'b0, ang} < duty_frac);
      neg1_r  <= idx[STB+1];
      addr1_r <= addr_nxt;
      r1_r    <= din.t_ge ? (RFB+1)'(1 << RFB) : {1'b0, din.frac[FB-1 -: RFB]};
      sq2_r   <= sq1_r;
      neg2_r  <= neg1_r;
      mag2_r  <= ROM[addr1_r];
      rp2_r   <= diff * $signed({1'b0, r1_r});
      sq3_r   <= sq2_r;
      sp3_r   <= level_b * sgn;
      rp3_r   <= rp2_r;
      rate_r  <= rate_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_rate  = rate_r;

  `RPG_ASSERT(a_mag_range, clk, rst_n, v2_r |-> (mag2_r <= 17'd65536), "sine magnitude above one")
  `RPG_ASSERT(a_square_out, clk, rst_n, (adv && v3_r && mode == MODE_SQUARE) |=> (out_rate == level_a || out_rate == 32'd0), "square level wrong")
endmodule

// ===== rtl/core/rate_profile_generator.sv =====
// ---------------------------------------------------------------------------
// rate_profile_generator
// Maps a microsecond time stamp to a target rate for the configured profile.
// ---------------------------------------------------------------------------
// One word is taken per clock while the output is not stalled, and each word
// gives one result word. The pipe is an entry register, then the restoring
// divider with one stage per bit (48 for time mod period, 16 for the fraction
// of the period), then angle/ramp ratio, sine table read with ramp multiply,
// sine multiply and the output register. The whole pipe advances whenever the
// output register is empty or being taken, so in_tready follows out_tready
// through one gate. Config must be static while words are in flight; the block
// does not enforce this. A period of 0 is treated as 1.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rate_profile_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // [47:0] time_us
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] rate
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [32:0] cfg_wdata
);
  import rpg_pkg::*;

  logic [1:0]         mode_r;
  logic [31:0]        level_a_r;
  logic signed [32:0] level_b_r;
  logic [31:0]        period_r;
  logic [15:0]        phase_r;
  logic [16:0]        duty_r;
  logic [PW-1:0]      period_eff;
  logic               adv;
  div_out_t           div_o;

  // config registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_CONST;
      level_a_r <= '0;
      level_b_r <= '0;
      period_r  <= 32'd1000000;
      phase_r   <= '0;
      duty_r    <= 17'd32768;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        REG_MODE:    mode_r    <= cfg_wdata[1:0];
        REG_LEVEL_A: level_a_r <= cfg_wdata[31:0];
        REG_LEVEL_B: level_b_r <= $signed(cfg_wdata);
        REG_PERIOD:  period_r  <= cfg_wdata[31:0];
        REG_PHASE:   phase_r   <= cfg_wdata[15:0];
        REG_DUTY:    duty_r    <= cfg_wdata[16:0];
        default:     ;
      endcase
    end
  end

  assign period_eff = (period_r == '0) ? 32'd1 : period_r;

  // pipe moves when the output word is gone or leaving
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  rpg_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid),
    .in_time  (in_tdata),
    .period   (period_eff),
    .dout     (div_o)
  );

  rpg_shaper u_shp (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .din        (div_o),
    .mode       (mode_r),
    .level_a    (level_a_r),
    .level_b    (level_b_r),
    .phase_turn (phase_r),
    .duty_frac  (duty_r),
    .out_valid  (out_tvalid),
    .out_rate   (out_tdata)
  );

  `RPG_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")
  `RPG_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "output word changed under stall")
endmodule
